// ----- hw/rtl/erfr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// erfr_pkg: shared types and constants for the receive frame ring
// Transaction payload structs, status codes and the CRC-32 bit step.
// ----------------------------------------------------------------------------
package erfr_pkg;

   // Number of FCS bytes appended to every stored frame.
   localparam int FCS_BYTES = 4;

   // Reflected Ethernet CRC-32 polynomial and its preset value.
   localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
   localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      STATUS_STORED    = 2'd0,
      STATUS_DISABLED  = 2'd1,
      STATUS_TOO_LARGE = 2'd2,
      STATUS_RING_FULL = 2'd3
   } frame_status_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_last;
      logic [3:0] consumer_slot;
   } req_type;

   typedef struct packed {
      frame_status_type frame_status;
      logic [3:0]       slot_used;
      logic [11:0]      stored_length;
      logic [31:0]      frame_fcs;
      logic [31:0]      missed_frames;
   } rsp_type;

   // One bit of the reflected CRC shift register.
   function automatic logic [31:0] crc_bit_step(input logic [31:0] crc);
      crc_bit_step = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/erfr_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// erfr_ram: generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module erfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ----- hw/rtl/ethernet_rx_frame_ring_with_fcs_unit.sv -----
// Sequence: a data byte is accepted and then shifted through eight CRC bit steps.
// A last byte is followed by any zero pad bytes, the finish state, the four FCS byte writes
// and the load of the response register; a dropped frame goes from the finish state to the response.
// The block takes no new byte until it is through with the last, as the single CRC register is bit-serial.
// Reset is synchronous: ring pointer, counters, CRC and enable return to their reset values;
// the frame memory and length table are not cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// ethernet_rx_frame_ring_with_fcs_unit: receive frame ring with FCS append
// Stores received bytes into a ring of frame slots, pads short frames, runs
// the Ethernet CRC-32 and appends it, then publishes or drops the slot.
// ----------------------------------------------------------------------------
module ethernet_rx_frame_ring_with_fcs_unit
   import erfr_pkg::*;
#(
   parameter int SLOT_BYTES = 2048,
   parameter int RING_SLOTS = 16,
   parameter int MIN_FRAME  = 60
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    csr_write_enable,
   input  wire logic    csr_write_data,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   // Byte positions inside one slot, slot index and whole-ring byte address.
   localparam int CNT_W  = $clog2(SLOT_BYTES);
   localparam int LEN_W  = CNT_W + 1;
   localparam int SLOT_W = $clog2(RING_SLOTS);
   localparam int ADDR_W = $clog2(SLOT_BYTES * RING_SLOTS);
   localparam int CMP_W  = (SLOT_W > 4) ? SLOT_W : 4;

   // A byte is stored only while the count is below this limit, which leaves
   // room for the FCS at the end of the slot.
   localparam logic [CNT_W-1:0] FILL_LIMIT = CNT_W'(SLOT_BYTES - FCS_BYTES);
   localparam logic [CNT_W-1:0] MIN_LEN    = CNT_W'(MIN_FRAME);
   localparam logic [2:0]       LAST_BIT   = 3'd7;
   localparam logic [2:0]       LAST_FCS   = 3'(FCS_BYTES - 1);

   // The sequencer walks every stored byte through the shared CRC register one bit a
   // cycle. FINISH decides between padding, dropping and appending the FCS.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BITS,
      ST_FINISH,
      ST_FCS,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic               enabled_ff, enabled_in;
   logic [CNT_W-1:0]   byte_count_ff, byte_count_in;
   logic [31:0]        crc_ff, crc_in;
   logic               oversize_ff, oversize_in;
   logic [SLOT_W-1:0]  write_slot_ff, write_slot_in;
   logic [31:0]        missed_ff, missed_in;
   logic [2:0]         step_ff, step_in;
   logic               last_ff, last_in;
   logic [3:0]         consumer_ff, consumer_in;
   frame_status_type   status_ff, status_in;
   logic [SLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic [LEN_W-1:0]   res_len_ff, res_len_in;
   logic [31:0]        res_fcs_ff, res_fcs_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // Memory write port, driven by the sequencer.
   logic               ram_we;
   logic [CNT_W-1:0]   ram_pos;
   logic [7:0]         ram_wdata;
   logic [ADDR_W-1:0]  ram_addr;
   logic               len_we;

   // Values used when the frame is finished.
   logic [31:0]        fcs_word;
   logic [SLOT_W-1:0]  next_slot;
   logic [LEN_W-1:0]   full_len;
   logic               ring_full;

   assign fcs_word  = ~crc_ff;
   assign next_slot = (write_slot_ff == SLOT_W'(RING_SLOTS - 1)) ? '0 : write_slot_ff + 1'b1;
   assign full_len  = LEN_W'(byte_count_ff) + LEN_W'(FCS_BYTES);
   // A consumer slot outside the ring never matches, so the ring never looks full.
   assign ring_full = (CMP_W'(next_slot) == CMP_W'(consumer_ff));

   assign ram_addr = ADDR_W'(write_slot_ff) * ADDR_W'(SLOT_BYTES) + ADDR_W'(ram_pos);

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      enabled_in    = csr_write_enable ? csr_write_data : enabled_ff;
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      oversize_in   = oversize_ff;
      write_slot_in = write_slot_ff;
      missed_in     = missed_ff;
      step_in       = step_ff;
      last_in       = last_ff;
      consumer_in   = consumer_ff;
      status_in     = status_ff;
      res_slot_in   = res_slot_ff;
      res_len_in    = res_len_ff;
      res_fcs_in    = res_fcs_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      ram_we        = 1'b0;
      ram_pos       = byte_count_ff;
      ram_wdata     = '0;
      len_we        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               last_in     = req_data.frame_last;
               consumer_in = req_data.consumer_slot;
               if (byte_count_ff < FILL_LIMIT) begin
                  ram_we        = 1'b1;
                  ram_wdata     = req_data.frame_byte;
                  crc_in        = crc_ff ^ {24'd0, req_data.frame_byte};
                  byte_count_in = byte_count_ff + 1'b1;
                  step_in       = '0;
                  state_in      = ST_BITS;
               end else begin
                  // No room left for this byte: the frame is marked too large.
                  oversize_in = 1'b1;
                  state_in    = req_data.frame_last ? ST_FINISH : ST_IDLE;
               end
            end
         end

         ST_BITS: begin
            crc_in  = crc_bit_step(crc_ff);
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_BIT) begin
               state_in = last_ff ? ST_FINISH : ST_IDLE;
            end
         end

         ST_FINISH: begin
            if (!enabled_ff || oversize_ff) begin
               // Disabled takes precedence over too large; neither is counted.
               status_in   = enabled_ff ? STATUS_TOO_LARGE : STATUS_DISABLED;
               res_slot_in = '0;
               res_len_in  = '0;
               res_fcs_in  = '0;
               state_in    = ST_EMIT;
            end else if (byte_count_ff < MIN_LEN) begin
               // Short frame: store one zero pad byte and run it through the CRC.
               ram_we        = 1'b1;
               byte_count_in = byte_count_ff + 1'b1;
               step_in       = '0;
               state_in      = ST_BITS;
            end else begin
               step_in  = '0;
               state_in = ST_FCS;
            end
         end

         ST_FCS: begin
            // FCS bytes go out least significant first.
            ram_we    = 1'b1;
            ram_pos   = byte_count_ff + CNT_W'(step_ff[1:0]);
            ram_wdata = fcs_word[{step_ff[1:0], 3'b000} +: 8];
            step_in   = step_ff + 1'b1;
            if (step_ff == LAST_FCS) begin
               len_we      = 1'b1;
               res_slot_in = write_slot_ff;
               res_len_in  = full_len;
               res_fcs_in  = fcs_word;
               if (ring_full) begin
                  // The slot stays written but unpublished.
                  missed_in = missed_ff + 1'b1;
                  status_in = STATUS_RING_FULL;
               end else begin
                  write_slot_in = next_slot;
                  status_in     = STATUS_STORED;
               end
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.frame_status  = status_ff;
               rsp_data_in.slot_used     = 4'(res_slot_ff);
               rsp_data_in.stored_length = 12'(res_len_ff);
               rsp_data_in.frame_fcs     = res_fcs_ff;
               rsp_data_in.missed_frames = missed_ff;
               // Every finished frame restarts the byte count and the CRC.
               byte_count_in             = '0;
               crc_in                    = CRC_PRESET;
               oversize_in               = 1'b0;
               state_in                  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         enabled_ff    <= 1'b0;
         byte_count_ff <= '0;
         crc_ff        <= CRC_PRESET;
         oversize_ff   <= 1'b0;
         write_slot_ff <= '0;
         missed_ff     <= '0;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         enabled_ff    <= enabled_in;
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
         oversize_ff   <= oversize_in;
         write_slot_ff <= write_slot_in;
         missed_ff     <= missed_in;
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      last_ff     <= last_in;
      consumer_ff <= consumer_in;
      status_ff   <= status_in;
      res_slot_ff <= res_slot_in;
      res_len_ff  <= res_len_in;
      res_fcs_ff  <= res_fcs_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Frame byte storage for the whole ring; its read port is not used here.
   erfr_ram #(
      .WIDTH (8),
      .DEPTH (SLOT_BYTES * RING_SLOTS)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_addr),
      .wr_data (ram_wdata),
      .rd_addr ('0),
      .rd_data ()
   );

   // Stored length of each slot.
   erfr_ram #(
      .WIDTH (12),
      .DEPTH (RING_SLOTS)
   ) u_slot_lengths (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (write_slot_ff),
      .wr_data (12'(full_len)),
      .rd_addr ('0),
      .rd_data ()
   );

endmodule
`default_nettype wire

// ----- bench/ethernet_rx_frame_ring_with_fcs_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ethernet_rx_frame_ring_with_fcs_unit_tb: self-checking bench for the frame ring
// Streams received frames byte by byte into the ring with random idle gaps on the
// request side and random back-pressure on results. A predictor tracks the write
// slot, CRC and missed count and checks every frame result. The run toggles the
// network enable, fills the ring, sends a slot-filling frame and oversized frames.
// ----------------------------------------------------------------------------
module ethernet_rx_frame_ring_with_fcs_unit_tb
   import erfr_pkg::*;
();

   localparam int SLOT_BYTES = 2048;
   localparam int RING_SLOTS = 16;
   localparam int MIN_FRAME  = 60;

   // No transaction on either channel for this many cycles means the block hung.
   // The slowest legal gap is a one-byte frame padded out to the minimum length,
   // so this leaves a wide margin.
   localparam int STALL_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 700;
   localparam int CSR_QUIET     = 40;
   localparam int RANDOM_BYTES  = 1950;
   localparam int PHASE_BYTES   = 325;
   localparam int MIN_FRAMES    = 60;

   // How the bytes of a frame are filled.
   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_STRIPES} fill_kind_type;
   // Where the consumer pointer sits when the last byte of a frame arrives.
   typedef enum int {AIM_ANY, AIM_FULL, AIM_HERE} aim_kind_type;

   // The class below follows the ring pointer, the CRC over the frame in progress
   // and the missed-frame counter, and keeps the frame results still to arrive.
   class frame_result_book_type;
      bit          link_up;
      logic [3:0]  fill_slot;
      int          bytes_in;
      logic [31:0] crc_acc;
      bit          overflowed;
      logic [31:0] lost_frames;
      rsp_type     pending[$];
      int          mismatches;
      int          status_seen[4];

      function new();
         link_up = 1'b0;
         fill_slot = '0;
         bytes_in = 0;
         crc_acc = CRC_PRESET;
         overflowed = 1'b0;
         lost_frames = '0;
         mismatches = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      // Reflected CRC-32 update over one byte, low bit first.
      function logic [31:0] fold_byte(logic [31:0] acc, logic [7:0] data);
         logic [31:0] value;
         value = acc ^ {24'd0, data};
         for (int k = 0; k < 8; k++) begin
            value = value[0] ? ((value >> 1) ^ CRC_POLY) : (value >> 1);
         end
         return value;
      endfunction

      // Called for every byte the block accepts.
      function void take_byte(req_type item);
         rsp_type    outcome;
         int         length;
         logic [3:0] next_slot;
         if (bytes_in < SLOT_BYTES - FCS_BYTES) begin
            crc_acc = fold_byte(crc_acc, item.frame_byte);
            bytes_in++;
         end else begin
            overflowed = 1'b1;
         end
         if (!item.frame_last) return;
         outcome = '0;
         if (!link_up) begin
            outcome.frame_status = STATUS_DISABLED;
         end else if (overflowed) begin
            outcome.frame_status = STATUS_TOO_LARGE;
         end else begin
            length = bytes_in;
            while (length < MIN_FRAME) begin
               crc_acc = fold_byte(crc_acc, 8'h00);
               length++;
            end
            outcome.slot_used = fill_slot;
            outcome.stored_length = 12'(length + FCS_BYTES);
            outcome.frame_fcs = ~crc_acc;
            next_slot = (int'(fill_slot) + 1 >= RING_SLOTS) ? 4'd0 : fill_slot + 4'd1;
            if (next_slot == item.consumer_slot) begin
               lost_frames++;
               outcome.frame_status = STATUS_RING_FULL;
            end else begin
               fill_slot = next_slot;
               outcome.frame_status = STATUS_STORED;
            end
         end
         outcome.missed_frames = lost_frames;
         bytes_in = 0;
         crc_acc = CRC_PRESET;
         overflowed = 1'b0;
         pending.push_back(outcome);
      endfunction

      // Called for every frame result the block hands over.
      function void match_result(rsp_type seen);
         rsp_type wanted;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result: status %0d slot %0d length %0d fcs %h missed %0d",
                        seen.frame_status, seen.slot_used, seen.stored_length,
                        seen.frame_fcs, seen.missed_frames);
            return;
         end
         wanted = pending.pop_front();
         status_seen[int'(wanted.frame_status)]++;
         if (seen.frame_status !== wanted.frame_status || seen.slot_used !== wanted.slot_used ||
             seen.stored_length !== wanted.stored_length ||
             seen.frame_fcs !== wanted.frame_fcs ||
             seen.missed_frames !== wanted.missed_frames) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Result differs, expected: status %0d slot %0d length %0d fcs %h missed %0d",
                        wanted.frame_status, wanted.slot_used, wanted.stored_length,
                        wanted.frame_fcs, wanted.missed_frames);
               $display("                  actual: status %0d slot %0d length %0d fcs %h missed %0d",
                        seen.frame_status, seen.slot_used, seen.stored_length,
                        seen.frame_fcs, seen.missed_frames);
            end
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    csr_write_enable;
   logic    csr_write_data;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // While calm is set neither side idles, so the block runs at its full rate.
   bit calm = 1'b0;
   int stall_cycles = 0;
   frame_result_book_type ring_book;

   always #10 clock = ~clock;

   ethernet_rx_frame_ring_with_fcs_unit #(
      .SLOT_BYTES(SLOT_BYTES),
      .RING_SLOTS(RING_SLOTS),
      .MIN_FRAME (MIN_FRAME)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data)
   );

   // Result side. The values seen here are those from before the edge, so the
   // check does not depend on the order in which processes wake up. The ready
   // line then stalls at random, with a chance of 31 in a hundred, unless calm is set.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) ring_book.match_result(rsp_data);
      rsp_ready <= calm || ($urandom_range(99) >= 31);
   end

   // The watchdog ends the run if no transaction happens for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles.", STALL_LIMIT);
         $display("ethernet_rx_frame_ring_with_fcs_unit: mismatch");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // The task offers one byte and returns at the edge where the block takes it.
   // An idle gap is inserted before the byte, not after it. This way valid is
   // assigned once in each time step, either lowered for the gap or kept high
   // with the new byte.
   task automatic send_byte(req_type item);
      int gap;
      if (!calm && $urandom_range(99) < 31) begin
         gap = $urandom_range(12, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      ring_book.take_byte(item);
   endtask

   // The task sends a whole frame. The consumer pointer is random on every byte,
   // but the last byte can instead aim it just past the write slot, which makes the
   // ring full, or at the write slot itself, the closest case that still stores the
   // frame.
   task automatic send_frame(int length, fill_kind_type fill, aim_kind_type aim);
      req_type item;
      for (int i = 0; i < length; i++) begin
         case (fill)
            FILL_ZERO: item.frame_byte = 8'h00;
            FILL_ONES: item.frame_byte = 8'hFF;
            FILL_STRIPES: item.frame_byte = i[0] ? 8'h55 : 8'hAA;
            default: item.frame_byte = 8'($urandom_range(255));
         endcase
         item.frame_last = (i == length - 1);
         item.consumer_slot = 4'($urandom_range(15));
         if (item.frame_last && aim == AIM_FULL)
            item.consumer_slot = ring_book.fill_slot + 4'd1;
         else if (item.frame_last && aim == AIM_HERE)
            item.consumer_slot = ring_book.fill_slot;
         send_byte(item);
      end
   endtask

   // The enable is changed only when the block is idle. The task drops valid,
   // waits until every expected result has arrived, and then waits a little
   // longer before it writes the register.
   task automatic set_network(bit on);
      req_valid <= 1'b0;
      @(posedge clock);
      while (ring_book.pending.size() != 0) @(posedge clock);
      repeat (CSR_QUIET) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= on;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      ring_book.link_up = on;
   endtask

   // Most random frames are short, so the padding path is exercised often.
   // Longer frames still appear now and then.
   function automatic int pick_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 50) return $urandom_range(8, 1);
      if (roll < 75) return $urandom_range(64, 9);
      if (roll < 95) return $urandom_range(160, 65);
      return $urandom_range(400, 161);
   endfunction

   initial begin
      int            random_bytes;
      int            random_frames;
      int            length;
      int            phase;
      int            roll;
      fill_kind_type fill;
      aim_kind_type  aim;

      ring_book = new();
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      req_valid = 1'b0;
      req_data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed frames. Minimal frames of all zeros and all ones are padded out
      // to the minimum length. A striped frame follows. Then come two ring-full
      // drops, a frame stored right at the consumer pointer, and disabled drops
      // that are not counted even when the ring would be full.
      set_network(1'b1);
      send_frame(1, FILL_ZERO, AIM_HERE);
      send_frame(1, FILL_ONES, AIM_ANY);
      send_frame(4, FILL_STRIPES, AIM_HERE);
      send_frame(1, FILL_ONES, AIM_FULL);
      send_frame(2, FILL_RANDOM, AIM_FULL);
      send_frame(3, FILL_ONES, AIM_HERE);
      set_network(1'b0);
      send_frame(2, FILL_ZERO, AIM_FULL);
      send_frame(1, FILL_ONES, AIM_HERE);
      set_network(1'b1);

      // Random frames in phases. The enable is set again at each phase boundary;
      // the fourth phase always runs with the network off. In the second phase neither
      // side idles.
      random_bytes = 0;
      random_frames = 0;
      phase = 0;
      while (random_bytes < RANDOM_BYTES || random_frames < MIN_FRAMES) begin
         if (random_bytes >= (phase + 1) * PHASE_BYTES) begin
            phase++;
            calm <= (phase == 2);
            set_network((phase == 4) ? 1'b0 : ($urandom_range(3) != 0));
         end
         roll = $urandom_range(99);
         fill = (roll < 5) ? FILL_ZERO : (roll < 10) ? FILL_ONES : FILL_RANDOM;
         roll = $urandom_range(99);
         aim = (roll < 20) ? AIM_FULL : (roll < 30) ? AIM_HERE : AIM_ANY;
         length = pick_length();
         send_frame(length, fill, aim);
         random_bytes += length;
         random_frames++;
      end
      calm <= 1'b0;

      // Large frames. The first one fills the slot exactly, which gives the
      // largest stored length. The next one is one byte too long and is dropped.
      // With the network off, an oversized frame must report a disabled drop.
      set_network(1'b1);
      send_frame(SLOT_BYTES - FCS_BYTES, FILL_RANDOM, AIM_ANY);
      send_frame(SLOT_BYTES - FCS_BYTES + 1, FILL_RANDOM, AIM_ANY);
      set_network(1'b0);
      send_frame(SLOT_BYTES, FILL_RANDOM, AIM_FULL);

      req_valid <= 1'b0;
      @(posedge clock);
      while (ring_book.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Frames checked: %0d stored, %0d disabled drops, %0d oversize drops, %0d ring full.",
               ring_book.status_seen[STATUS_STORED], ring_book.status_seen[STATUS_DISABLED],
               ring_book.status_seen[STATUS_TOO_LARGE], ring_book.status_seen[STATUS_RING_FULL]);
      $display("Random part: %0d bytes in %0d frames; %0d mismatches.",
               random_bytes, random_frames, ring_book.mismatches);
      if (ring_book.mismatches == 0 && ring_book.pending.size() == 0) begin
         $display("ethernet_rx_frame_ring_with_fcs_unit: match");
      end else begin
         $display("ethernet_rx_frame_ring_with_fcs_unit: mismatch");
      end
      $finish;
   end

endmodule
